[rtl/core/i8dq_pkg.sv]
// Shared types and constants for the int8 dot product dequantizer.
package i8dq_pkg;

   // Longest dot product that is summed; longer ones are flagged
   localparam int MAX_DOT_LENGTH = 4096;
   localparam int COUNT_W        = $clog2(MAX_DOT_LENGTH + 2);

   // Job queue between the accumulate front and the dequantize back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // Register indexes and port widths of the CSR write port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCUMULATE_MODE     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FRACTION_BITS = 1'd1;
   localparam logic [5:0] SCALE_FRACTION_BITS_RESET = 6'd24;

   // 48-bit output limits, sign extended to the 64-bit working width
   localparam logic signed [63:0] VALUE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] VALUE_MIN = 64'shFFFF_8000_0000_0000;

   typedef struct packed {
      logic [7:0]         activation;
      logic signed [7:0]  weight;
      logic               last;
      logic [7:0]         zero_point;
      logic signed [19:0] column_sum;
      logic [31:0]        combined_scale;
      logic signed [47:0] bias;
      logic signed [47:0] prior;
   } req_type;

   typedef struct packed {
      logic signed [47:0] value;
      logic signed [27:0] dot_sum;
      logic               saturated;
      logic               too_long;
   } rsp_type;

   // One closed dot product waiting for dequantization
   typedef struct packed {
      logic signed [27:0] dot_sum;
      logic               too_long;
      logic [7:0]         zero_point;
      logic signed [19:0] column_sum;
      logic [31:0]        combined_scale;
      logic signed [47:0] bias;
      logic signed [47:0] prior;
   } job_type;

   typedef struct packed {
      logic       accumulate_mode;
      logic [5:0] scale_fraction_bits;
   } csr_type;

endpackage

[rtl/core/int8_dot_product_dequantizer_core.sv]
// Top level of the int8 dot product dequantizer: CSRs, front, job queue, back.
//
//   channel   direction  handshake                   payload
//   req       in         push / full                 req_data  (i8dq_pkg::req_type)
//   rsp       out        empty / pop                 rsp_data  (i8dq_pkg::rsp_type)
//   csr       in         csr_write_enable, no wait   csr_index, csr_data
//
// The front accumulates one pair per cycle; every beat, closing or not, stalls while full.
// Each closing item becomes a job; the back runs each job through its sequencer steps (pop,
// correct, multiply, shift, sum) and pops the next job only after the sum step is done.
// Up to 4 jobs wait in the queue; full rises when it holds 4, and the back holds
// in its sum step while an unread result sits in the output register.
// Synchronous active-high reset clears the sums, queue, sequencer and result flag.
module int8_dot_product_dequantizer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  i8dq_pkg::req_type                   req_data,
   output logic                                empty,
   input  logic                                pop,
   output i8dq_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [i8dq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i8dq_pkg::CSR_DATA_W-1:0]     csr_data
);
   import i8dq_pkg::*;

   csr_type csr_ff, csr_in;
   logic    take;
   logic    job_push, job_pop, job_empty, queue_full;
   job_type push_job, head_job;
   logic    rsp_valid;

   // Register writes
   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ACCUMULATE_MODE:     csr_in.accumulate_mode     = csr_data[0];
            CSR_SCALE_FRACTION_BITS: csr_in.scale_fraction_bits = csr_data[5:0];
            default:                 csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.accumulate_mode     <= 1'b0;
         csr_ff.scale_fraction_bits <= SCALE_FRACTION_BITS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign full  = queue_full;
   assign take  = push & ~queue_full;
   assign empty = ~rsp_valid;

   i8dq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .req_data (req_data),
      .job_push (job_push),
      .job      (push_job)
   );

   i8dq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (job_pop),
      .head_job (head_job),
      .empty    (job_empty)
   );

   i8dq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .job_empty (job_empty),
      .head_job  (head_job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_take  (pop & rsp_valid)
   );

endmodule

[rtl/core/i8dq_front.sv]
// Accumulate front: running dot product, pair count and job hand-off.
module i8dq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  i8dq_pkg::req_type req_data,
   output logic              job_push,
   output i8dq_pkg::job_type job
);
   import i8dq_pkg::*;

   logic signed [27:0]  running_sum_ff, running_sum_in;
   logic [COUNT_W-1:0]  pair_count_ff, pair_count_in;
   logic signed [16:0]  pair_product;
   logic signed [27:0]  sum_next;
   logic [COUNT_W-1:0]  count_next;

   // Add the pair unless the length bound is already reached
   always_comb begin
      pair_product = $signed({1'b0, req_data.activation}) * req_data.weight;
      if (pair_count_ff < COUNT_W'(MAX_DOT_LENGTH)) begin
         sum_next   = running_sum_ff + 28'(pair_product);
         count_next = pair_count_ff + 1'b1;
      end else begin
         sum_next   = running_sum_ff;
         count_next = COUNT_W'(MAX_DOT_LENGTH + 1);
      end
   end

   // Clear on the closing pair, otherwise advance
   always_comb begin
      running_sum_in = running_sum_ff;
      pair_count_in  = pair_count_ff;
      if (take) begin
         if (req_data.last) begin
            running_sum_in = '0;
            pair_count_in  = '0;
         end else begin
            running_sum_in = sum_next;
            pair_count_in  = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_sum_ff <= '0;
         pair_count_ff  <= '0;
      end else begin
         running_sum_ff <= running_sum_in;
         pair_count_ff  <= pair_count_in;
      end
   end

   // Closing pair hands its sum and operands to the back
   assign job_push           = take & req_data.last;
   assign job.dot_sum        = sum_next;
   assign job.too_long       = count_next > COUNT_W'(MAX_DOT_LENGTH);
   assign job.zero_point     = req_data.zero_point;
   assign job.column_sum     = req_data.column_sum;
   assign job.combined_scale = req_data.combined_scale;
   assign job.bias           = req_data.bias;
   assign job.prior          = req_data.prior;

endmodule

[rtl/core/i8dq_queue.sv]
// Short job queue between the accumulate front and the dequantize back.
module i8dq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  i8dq_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output i8dq_pkg::job_type head_job,
   output logic              empty
);
   import i8dq_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign head_job = entry_ff[rd_ptr_ff];

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/core/i8dq_back.sv]
// Dequantize back: zero-point correction, scale, rounding shift, bias and saturation.
module i8dq_back (
   input  logic              clock,
   input  logic              reset,
   input  i8dq_pkg::csr_type csr,
   input  logic              job_empty,
   input  i8dq_pkg::job_type head_job,
   output logic              job_pop,
   output logic              rsp_valid,
   output i8dq_pkg::rsp_type rsp_data,
   input  logic              rsp_take
);
   import i8dq_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CORR  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;

   logic [2:0]         state_ff, state_in;
   job_type            job_ff;
   logic signed [28:0] corr_ff, corr_in;
   logic signed [28:0] zp_term;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] scaled_ff, scaled_in;
   logic signed [63:0] half, rounded, total;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               slot_free, result_write;

   // Zero-point correction
   always_comb begin
      zp_term = $signed({1'b0, job_ff.zero_point}) * job_ff.column_sum;
      corr_in = 29'(job_ff.dot_sum) - zp_term;
   end

   // Scale multiply: 29-bit signed by 32-bit unsigned
   assign prod_in = 64'(corr_ff) * $signed({1'b0, job_ff.combined_scale});

   // Round half up, then floor shift
   always_comb begin
      if (csr.scale_fraction_bits == '0) begin
         half = '0;
      end else begin
         half = 64'sd1 <<< (csr.scale_fraction_bits - 6'd1);
      end
      rounded   = prod_ff + half;
      scaled_in = rounded >>> csr.scale_fraction_bits;
   end

   // Bias, optional prior, clamp to 48 bits
   always_comb begin
      total = scaled_ff + 64'(job_ff.bias)
            + (csr.accumulate_mode ? 64'(job_ff.prior) : 64'sd0);
      rsp_data_in.dot_sum  = job_ff.dot_sum;
      rsp_data_in.too_long = job_ff.too_long;
      if (total > VALUE_MAX) begin
         rsp_data_in.value     = VALUE_MAX[47:0];
         rsp_data_in.saturated = 1'b1;
      end else if (total < VALUE_MIN) begin
         rsp_data_in.value     = VALUE_MIN[47:0];
         rsp_data_in.saturated = 1'b1;
      end else begin
         rsp_data_in.value     = total[47:0];
         rsp_data_in.saturated = 1'b0;
      end
   end

   assign slot_free    = ~rsp_valid_ff | rsp_take;
   assign result_write = (state_ff == ST_SUM) & slot_free;
   assign job_pop      = (state_ff == ST_IDLE) & ~job_empty;

   // Sequence one job through the steps
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (~job_empty) begin
               state_in = ST_CORR;
            end
         end
         ST_CORR:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SHIFT;
         ST_SHIFT: state_in = ST_SUM;
         ST_SUM: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Result register: hold until popped
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= head_job;
      end
      if (state_ff == ST_CORR) begin
         corr_ff <= corr_in;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= prod_in;
      end
      if (state_ff == ST_SHIFT) begin
         scaled_ff <= scaled_in;
      end
      if (result_write) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/i8dq_checker.sv]
// Port-level checker for the int8 dot product dequantizer, bound to the top level.
module i8dq_checker (
   input logic              clock,
   input logic              reset,
   input logic              push,
   input logic              full,
   input i8dq_pkg::req_type req_data,
   input logic              empty,
   input logic              pop,
   input i8dq_pkg::rsp_type rsp_data
);
   import i8dq_pkg::*;

   // Reset leaves both sides idle
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("block not idle after reset");

   // Queue fills only from an accepted closing beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push && req_data.last))
      else $error("full rose without a closing beat");

   // A waiting result holds until popped
   assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_data))
      else $error("result changed or vanished before pop");

   // Results leave only through pop
   assert property (@(posedge clock) disable iff (reset)
      $rose(empty) |-> $past(pop))
      else $error("result dropped without pop");

endmodule

bind int8_dot_product_dequantizer_core i8dq_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .req_data (req_data),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

[tb/int8_dot_product_dequantizer_checker.sv]
`timescale 1ns / 1ps
// Checker for the int8 dot product dequantizer: predicts each result beat and compares it.
module int8_dot_product_dequantizer_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic                                full,
   input  i8dq_pkg::req_type                   req_data,
   input  logic                                empty,
   input  logic                                pop,
   input  i8dq_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [i8dq_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [i8dq_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                  fail_count,
   output int                                  pending
);
   import i8dq_pkg::*;

   // Shadow copy of the CSRs and the accumulate front
   logic               mode_accumulate;
   logic [5:0]         frac_shift;
   logic signed [27:0] dot_acc;
   int                 pairs_taken;
   rsp_type            expected_results[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // Print one line per mismatch and count it
   task automatic flag_mismatch(input string what, input longint got, input longint want);
      fail_count++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Fold one input beat into the dot product; return 1 with the result on a closing beat
   function automatic bit dequantize_beat(input req_type beat, output rsp_type outcome);
      longint corrected;
      longint product;
      longint half;
      longint scaled;
      longint total;
      outcome = '0;
      // drop pairs past the length bound, keep the count pinned one above it
      if (pairs_taken < MAX_DOT_LENGTH) begin
         dot_acc = dot_acc + 28'(longint'(beat.activation) * longint'(beat.weight));
         pairs_taken++;
      end else begin
         pairs_taken = MAX_DOT_LENGTH + 1;
      end
      if (!beat.last)
         return 1'b0;

      // zero-point correction, scale, round half up, then bias and prior
      corrected = longint'(dot_acc) - longint'(beat.zero_point) * longint'(beat.column_sum);
      product   = corrected * longint'(beat.combined_scale);
      half      = (frac_shift == 6'd0) ? 64'sd0 : (longint'(1) << (frac_shift - 1));
      scaled    = (product + half) >>> frac_shift;
      total     = scaled + longint'(beat.bias);
      if (mode_accumulate)
         total = total + longint'(beat.prior);

      // clamp to the 48-bit output range
      outcome.saturated = 1'b0;
      if (total > VALUE_MAX) begin
         total = VALUE_MAX;
         outcome.saturated = 1'b1;
      end else if (total < VALUE_MIN) begin
         total = VALUE_MIN;
         outcome.saturated = 1'b1;
      end
      outcome.value    = total[47:0];
      outcome.dot_sum  = dot_acc;
      outcome.too_long = (pairs_taken > MAX_DOT_LENGTH);

      dot_acc     = '0;
      pairs_taken = 0;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type fresh;
      if (reset) begin
         mode_accumulate = 1'b0;
         frac_shift      = SCALE_FRACTION_BITS_RESET;
         dot_acc         = '0;
         pairs_taken     = 0;
         expected_results.delete();
         pending <= 0;
      end else begin
         // track CSR writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_ACCUMULATE_MODE:     mode_accumulate = csr_data[0];
               CSR_SCALE_FRACTION_BITS: frac_shift      = csr_data;
               default: ;
            endcase
         end

         // compare the result beat with the oldest expectation
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected result value", rsp_data.value, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.value !== want.value)
                  flag_mismatch("value", rsp_data.value, want.value);
               if (rsp_data.dot_sum !== want.dot_sum)
                  flag_mismatch("dot_sum", rsp_data.dot_sum, want.dot_sum);
               if (rsp_data.saturated !== want.saturated)
                  flag_mismatch("saturated", rsp_data.saturated, want.saturated);
               if (rsp_data.too_long !== want.too_long)
                  flag_mismatch("too_long", rsp_data.too_long, want.too_long);
            end
         end

         // predict from the input beat
         if (push && !full) begin
            if (dequantize_beat(req_data, fresh))
               expected_results.push_back(fresh);
         end

         pending <= expected_results.size();
      end
   end

endmodule

[tb/tb_int8_dot_product_dequantizer_core.sv]
`timescale 1ns / 1ps
// Testbench top for the int8 dot product dequantizer: stimulus, flow control and verdict.
module tb_int8_dot_product_dequantizer_core;
   import i8dq_pkg::*;

   localparam int STALL_LIMIT            = 5000;
   localparam int SETTLE_CYCLES          = 12;
   localparam int DRAIN_CYCLES           = 24;
   localparam int BACKLOG_CYCLES         = 400;
   localparam int RANDOM_ITEMS_PER_PHASE = 128;
   localparam int PHASE_COUNT            = 9;

   localparam logic signed [47:0] TOP48    = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] BOTTOM48 = 48'sh8000_0000_0000;

   typedef enum logic [1:0] {DRAIN_ALL, DRAIN_HALF, DRAIN_SPARSE, DRAIN_MOST} drain_pattern_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   push             = 1'b0;
   logic                   full;
   req_type                req_data         = '0;
   logic                   empty;
   logic                   pop              = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_data         = '0;

   int fail_count;
   int pending;
   int burst_left      = 1;
   bit backlog_request = 1'b0;

   int8_dot_product_dequantizer_core DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data         (req_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   int8_dot_product_dequantizer_checker watch (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_data         (req_data),
      .empty            (empty),
      .pop              (pop),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random value biased toward the edges of a field of the given width
   function automatic logic [63:0] spread_bits(input int width);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return 64'(1) << (width - 1);
         3:       return ~(64'(1) << (width - 1));
         4:       return 64'(1) << $urandom_range(0, width - 1);
         5:       return 64'(longint'($urandom_range(0, 300)) - 150);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_beat(input bit close);
      req_type beat;
      beat.activation     = 8'(spread_bits(8));
      beat.weight         = 8'(spread_bits(8));
      beat.last           = close;
      beat.zero_point     = 8'(spread_bits(8));
      beat.column_sum     = 20'(spread_bits(20));
      beat.combined_scale = 32'(spread_bits(32));
      beat.bias           = 48'(spread_bits(48));
      beat.prior          = 48'(spread_bits(48));
      return beat;
   endfunction

   function automatic req_type make_beat(
      input logic [7:0] act, input logic signed [7:0] wgt, input bit close,
      input logic [7:0] zp, input logic signed [19:0] csum, input logic [31:0] scale,
      input logic signed [47:0] bias, input logic signed [47:0] prior);
      req_type beat;
      beat.activation     = act;
      beat.weight         = wgt;
      beat.last           = close;
      beat.zero_point     = zp;
      beat.column_sum     = csum;
      beat.combined_scale = scale;
      beat.bias           = bias;
      beat.prior          = prior;
      return beat;
   endfunction

   // Offer one beat, hold it until taken, then idle at the end of a burst
   task automatic offer(input req_type beat);
      push     <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   task automatic send_dot(input int len);
      for (int i = 0; i < len; i++)
         offer(random_beat(i == len - 1));
   endtask

   // Whole dot products of mostly short length until the item budget is spent
   task automatic random_run(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
            6, 7, 8:          len = $urandom_range(5, 24);
            default:          len = $urandom_range(25, 80);
         endcase
         send_dot(len);
         sent += len;
      end
   endtask

   // Stop offering, wait for every expected beat, then let the back finish
   task automatic settle(input int extra);
      push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_settings(input bit accumulate, input logic [5:0] shift);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_ACCUMULATE_MODE;
      csr_data         <= {5'($urandom), accumulate};
      @(posedge clock);
      csr_index        <= CSR_SCALE_FRACTION_BITS;
      csr_data         <= shift;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Receiver: changing pop patterns, plus one long hold-off on request
   initial begin : receiver
      drain_pattern_type pattern;
      int span;
      int hold;
      bit backlog_served;
      pattern        = DRAIN_ALL;
      span           = 0;
      hold           = 0;
      backlog_served = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (backlog_request && !backlog_served) begin
            backlog_served = 1'b1;
            hold = BACKLOG_CYCLES;
         end
         if (hold > 0) begin
            pop <= 1'b0;
            hold--;
         end else begin
            if (span == 0) begin
               pattern = drain_pattern_type'($urandom_range(0, 3));
               span    = $urandom_range(10, 80);
            end
            span--;
            case (pattern)
               DRAIN_ALL:    pop <= 1'b1;
               DRAIN_HALF:   pop <= 1'($urandom_range(0, 1));
               DRAIN_SPARSE: pop <= ($urandom_range(0, 7) == 0);
               default:      pop <= ($urandom_range(0, 3) != 0);
            endcase
         end
         @(posedge clock);
      end
   end

   // Watchdog: end the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("[int8_dot_product_dequantizer_core] ERROR");
      $finish;
   end

   initial begin : stimulus
      int ph;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         // reprogram only with the block drained
         if (ph > 0) begin
            settle(SETTLE_CYCLES);
            case (ph)
               1:       write_settings(1'b1, 6'd0);
               2:       write_settings(1'b0, 6'd1);
               3:       write_settings(1'b1, 6'd47);
               4:       write_settings(1'b0, 6'd63);
               5:       write_settings(1'b1, 6'd48);
               6:       write_settings(1'b0, 6'd24);
               default: write_settings(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)));
            endcase
         end

         // directed beats for the current settings
         case (ph)
            0: begin
               // overwrite mode, shift 24: saturation both ways, ties round upward
               offer(make_beat(8'd255, 8'sh80, 1'b1, 8'd255, 20'sh80000, 32'hFFFF_FFFF,
                               TOP48, BOTTOM48));
               offer(make_beat(8'd255, 8'sh7F, 1'b1, 8'd0, 20'sh0, 32'h0, BOTTOM48, TOP48));
               offer(make_beat(8'd0, 8'sh0, 1'b0, 8'hFF, 20'sh7FFFF, 32'hFFFF_FFFF,
                               TOP48, TOP48));
               offer(make_beat(8'd128, 8'shFF, 1'b1, 8'd255, 20'sh7FFFF, 32'hFFFF_FFFF,
                               BOTTOM48, 48'sh0));
               offer(make_beat(8'd1, 8'sh01, 1'b1, 8'd0, 20'sh0, 32'h0080_0000, 48'sh0, 48'sh0));
               offer(make_beat(8'd1, 8'shFF, 1'b1, 8'd0, 20'sh0, 32'h0080_0000, 48'sh0, 48'sh0));
               offer(make_beat(8'd3, 8'sh01, 1'b1, 8'd0, 20'sh0, 32'h0080_0000, 48'sh0, 48'sh0));
            end
            1: begin
               // accumulate mode, no shift: bias plus prior past both limits
               offer(make_beat(8'd255, 8'sh7F, 1'b1, 8'd0, 20'sh0, 32'h1, TOP48, TOP48));
               offer(make_beat(8'd255, 8'sh80, 1'b1, 8'd0, 20'sh0, 32'h1, BOTTOM48, BOTTOM48));
               offer(make_beat(8'd255, 8'sh80, 1'b1, 8'd255, 20'sh80000, 32'hFFFF_FFFF,
                               48'sh0, 48'shFFFF_FFFF_FFFF));
               offer(make_beat(8'd0, 8'sh0, 1'b1, 8'd0, 20'sh0, 32'h0, TOP48, 48'sh0));
            end
            3: begin
               // shift 47: exact ties on either side of zero
               offer(make_beat(8'd0, 8'sh0, 1'b1, 8'd1, 20'shF8000, 32'h8000_0000,
                               48'sh0, 48'sh0));
               offer(make_beat(8'd0, 8'sh0, 1'b1, 8'd1, 20'sh08000, 32'h8000_0000,
                               48'sh0, 48'sh0));
            end
            4: begin
               // shift 63: largest product shifts out entirely
               offer(make_beat(8'd255, 8'sh80, 1'b1, 8'd255, 20'sh80000, 32'hFFFF_FFFF,
                               48'sh1, TOP48));
            end
            default: ;
         endcase

         // fill the job queue while the receiver holds off
         if (ph == 2)
            backlog_request = 1'b1;

         random_run(RANDOM_ITEMS_PER_PHASE);
      end

      settle(DRAIN_CYCLES);
      if (fail_count == 0 && pending == 0)
         $display("[int8_dot_product_dequantizer_core] OK");
      else
         $display("[int8_dot_product_dequantizer_core] ERROR");
      $finish;
   end

endmodule
